// ===== rtl/mau_pkg.sv =====
package mau_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OP_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_ROWS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_A_COLS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_COLS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALAR  = 3'd4;

    // field widths
    localparam int DIM_W    = 4;
    localparam int CDIM_W   = 5;
    localparam int SCALAR_W = 16;
    localparam int VALUE_W  = 36;
    localparam int IDX_W    = 3;

    typedef enum logic [1:0] {
        MODE_ADD   = 2'd0,
        MODE_SUB   = 2'd1,
        MODE_SCALE = 2'd2,
        MODE_MUL   = 2'd3
    } mode_t;

    // reset values
    localparam mode_t                MODE_RST   = MODE_MUL;
    localparam logic [DIM_W-1:0]     DIM_RST    = 4'd8;
    localparam logic [SCALAR_W-1:0]  SCALAR_RST = 16'sd256;

    typedef enum logic [1:0] {
        ST_LOAD  = 2'd0,
        ST_ISSUE = 2'd1,
        ST_DRAIN = 2'd2
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic             wr_a;
        logic             wr_b;
        logic             rd;
        logic             first_k;
        logic             last_k;
        logic             last_el;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        mode_t             mode;
        logic [CDIM_W-1:0] rows;
        logic [CDIM_W-1:0] cols;
        logic [CDIM_W-1:0] bcols;
        logic              adv;
        logic              cfg_hit;
        logic              done;
    } status_t;

endpackage

// ===== rtl/mau_load_if.sv =====
interface mau_load_if #(
    parameter int ELEMENT_WIDTH = 16
);
    logic                            valid;
    logic                            ready;
    logic signed [ELEMENT_WIDTH-1:0] element;

    modport source (output valid, output element, input ready);
    modport sink   (input valid, input element, output ready);
endinterface

// ===== rtl/mau_result_if.sv =====
interface mau_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mau_pkg::VALUE_W-1:0]   value;
    logic        [mau_pkg::IDX_W-1:0]     out_row;
    logic        [mau_pkg::IDX_W-1:0]     out_col;
    logic                                 last;

    modport source (output valid, output value, output out_row, output out_col,
                    output last, input ready);
    modport sink   (input valid, input value, input out_row, input out_col,
                    input last, output ready);
endinterface

// ===== rtl/mau_ram.sv =====
module mau_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/mau_ctrl.sv =====
module mau_ctrl #(
    parameter int MAX_DIM = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  mau_pkg::status_t       stat,
    output mau_pkg::cmd_t          cmd,
    output logic [(MAX_DIM*MAX_DIM > 1 ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] wr_addr,
    output logic [(MAX_DIM*MAX_DIM > 1 ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] rd_addr_a,
    output logic [(MAX_DIM*MAX_DIM > 1 ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] rd_addr_b
);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int LW    = $clog2(2 * DEPTH + 1);

    mau_pkg::state_t state_reg, state_next;
    logic [LW-1:0]   lc_reg, lc_next;
    logic [DW-1:0]   r_reg, r_next;
    logic [DW-1:0]   c_reg, c_next;
    logic [DW-1:0]   k_reg, k_next;

    logic [LW-1:0] rows_w, cols_w, bcols_w, ocols_w;
    logic [LW-1:0] na, nb, total, b_off, a_idx, b_idx;
    logic          is_mul, accept, load_end;
    logic          k_end, c_end, r_end, issue, issue_end;

    assign rows_w  = LW'(stat.rows);
    assign cols_w  = LW'(stat.cols);
    assign bcols_w = LW'(stat.bcols);
    assign is_mul  = (stat.mode == mau_pkg::MODE_MUL);
    assign ocols_w = is_mul ? bcols_w : cols_w;

    // element counts of the load sequence
    assign na = rows_w * cols_w;
    always_comb
    begin
        case (stat.mode)
            mau_pkg::MODE_SCALE: nb = '0;
            mau_pkg::MODE_MUL:   nb = cols_w * bcols_w;
            default:             nb = na;
        endcase
    end
    assign total = na + nb;

    assign accept   = in_valid && in_ready;
    assign load_end = (lc_reg + LW'(1)) == total;
    assign b_off    = lc_reg - na;

    // result walk: row, column, and dot product index in multiply
    assign k_end     = !is_mul || ((LW'(k_reg) + LW'(1)) == cols_w);
    assign c_end     = (LW'(c_reg) + LW'(1)) == ocols_w;
    assign r_end     = (LW'(r_reg) + LW'(1)) == rows_w;
    assign issue     = (state_reg == mau_pkg::ST_ISSUE) && stat.adv;
    assign issue_end = k_end && c_end && r_end;

    assign a_idx = is_mul ? (LW'(r_reg) * cols_w + LW'(k_reg))
                          : (LW'(r_reg) * cols_w + LW'(c_reg));
    assign b_idx = is_mul ? (LW'(k_reg) * bcols_w + LW'(c_reg)) : a_idx;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mau_pkg::ST_LOAD:
            begin
                if (accept && load_end && !stat.cfg_hit)
                begin
                    state_next = mau_pkg::ST_ISSUE;
                end
            end
            mau_pkg::ST_ISSUE:
            begin
                if (issue && issue_end)
                begin
                    state_next = mau_pkg::ST_DRAIN;
                end
            end
            mau_pkg::ST_DRAIN:
            begin
                if (stat.done)
                begin
                    state_next = mau_pkg::ST_LOAD;
                end
            end
            default: state_next = mau_pkg::ST_LOAD;
        endcase
    end

    // counters
    always_comb
    begin
        lc_next = lc_reg;
        r_next  = r_reg;
        c_next  = c_reg;
        k_next  = k_reg;
        if (stat.cfg_hit)
        begin
            lc_next = '0;
        end
        else if (accept)
        begin
            lc_next = load_end ? '0 : lc_reg + LW'(1);
        end
        if (issue)
        begin
            if (!k_end)
            begin
                k_next = k_reg + DW'(1);
            end
            else
            begin
                k_next = '0;
                if (!c_end)
                begin
                    c_next = c_reg + DW'(1);
                end
                else
                begin
                    c_next = '0;
                    r_next = r_end ? '0 : r_reg + DW'(1);
                end
            end
        end
    end

    // outputs
    always_comb
    begin
        in_ready    = 1'b0;
        cmd         = '0;
        cmd.first_k = (k_reg == '0);
        cmd.last_k  = k_end;
        cmd.last_el = issue_end;
        cmd.row     = mau_pkg::IDX_W'(r_reg);
        cmd.col     = mau_pkg::IDX_W'(c_reg);
        case (state_reg)
            mau_pkg::ST_LOAD:
            begin
                in_ready = 1'b1;
                cmd.wr_a = accept && (lc_reg < na);
                cmd.wr_b = accept && !(lc_reg < na);
            end
            mau_pkg::ST_ISSUE:
            begin
                cmd.rd = issue;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign wr_addr   = (lc_reg < na) ? lc_reg[AW-1:0] : b_off[AW-1:0];
    assign rd_addr_a = a_idx[AW-1:0];
    assign rd_addr_b = b_idx[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mau_pkg::ST_LOAD;
            lc_reg    <= '0;
            r_reg     <= '0;
            c_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lc_reg    <= lc_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
            k_reg     <= k_next;
        end
    end
endmodule

// ===== rtl/mau_dp.sv =====
module mau_dp #(
    parameter int MAX_DIM       = 8,
    parameter int ELEMENT_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mau_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mau_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic signed [ELEMENT_WIDTH-1:0]     element,
    input  mau_pkg::cmd_t                       cmd,
    input  logic [(MAX_DIM*MAX_DIM > 1 ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] wr_addr,
    input  logic [(MAX_DIM*MAX_DIM > 1 ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] rd_addr_a,
    input  logic [(MAX_DIM*MAX_DIM > 1 ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] rd_addr_b,
    output mau_pkg::status_t                    stat,
    mau_result_if.source                        result
);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int EW    = ELEMENT_WIDTH;
    localparam int MW    = (EW > mau_pkg::SCALAR_W) ? EW : mau_pkg::SCALAR_W;
    localparam int PRW   = EW + MW;
    localparam int VW    = mau_pkg::VALUE_W;
    localparam int CW    = mau_pkg::CDIM_W;

    function automatic logic [CW-1:0] clamp_dim(input logic [mau_pkg::DIM_W-1:0] d);
        logic [CW-1:0] dx;
        dx = CW'(d);
        if (dx == '0)
        begin
            return CW'(1);
        end
        if (dx > CW'(MAX_DIM))
        begin
            return CW'(MAX_DIM);
        end
        return dx;
    endfunction

    // configuration registers
    mau_pkg::mode_t                       mode_reg;
    logic [mau_pkg::DIM_W-1:0]            a_rows_reg, a_cols_reg, b_cols_reg;
    logic signed [mau_pkg::SCALAR_W-1:0]  scalar_reg;
    logic                                 cfg_hit;

    assign cfg_hit = cfg_we && (cfg_index <= mau_pkg::REG_SCALAR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= mau_pkg::MODE_RST;
            a_rows_reg <= mau_pkg::DIM_RST;
            a_cols_reg <= mau_pkg::DIM_RST;
            b_cols_reg <= mau_pkg::DIM_RST;
            scalar_reg <= mau_pkg::SCALAR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mau_pkg::REG_OP_MODE: mode_reg   <= mau_pkg::mode_t'(cfg_data[1:0]);
                mau_pkg::REG_A_ROWS:  a_rows_reg <= cfg_data[mau_pkg::DIM_W-1:0];
                mau_pkg::REG_A_COLS:  a_cols_reg <= cfg_data[mau_pkg::DIM_W-1:0];
                mau_pkg::REG_B_COLS:  b_cols_reg <= cfg_data[mau_pkg::DIM_W-1:0];
                mau_pkg::REG_SCALAR:  scalar_reg <= cfg_data;
                default:              mode_reg   <= mode_reg;
            endcase
        end
    end

    // element stores
    logic                 adv;
    logic [EW-1:0]        a_raw, b_raw;
    logic signed [EW-1:0] a_q, b_q;

    mau_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_store_a (
        .clk   (clk),
        .we    (cmd.wr_a),
        .waddr (wr_addr),
        .wdata (element),
        .re    (cmd.rd),
        .raddr (rd_addr_a),
        .rdata (a_raw)
    );

    mau_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_store_b (
        .clk   (clk),
        .we    (cmd.wr_b),
        .waddr (wr_addr),
        .wdata (element),
        .re    (cmd.rd),
        .raddr (rd_addr_b),
        .rdata (b_raw)
    );

    assign a_q = a_raw;
    assign b_q = b_raw;

    // everything moves together unless the output register is blocked
    assign adv = !result.valid || result.ready;

    mau_pkg::cmd_t s1_reg, s2_reg;
    logic          s1_v_reg, s2_v_reg;

    // term stage: one multiplier shared by scale and multiply
    logic signed [MW-1:0]  mul_b;
    logic signed [PRW-1:0] prod, shifted;
    logic signed [VW-1:0]  term_next, term_reg;
    logic signed [VW-1:0]  acc_next, acc_reg;

    assign mul_b   = (mode_reg == mau_pkg::MODE_SCALE) ? MW'(scalar_reg) : MW'(b_q);
    assign prod    = a_q * mul_b;
    assign shifted = prod >>> 8;

    always_comb
    begin
        case (mode_reg)
            mau_pkg::MODE_ADD:   term_next = VW'(a_q) + VW'(b_q);
            mau_pkg::MODE_SUB:   term_next = VW'(a_q) - VW'(b_q);
            mau_pkg::MODE_SCALE: term_next = VW'(shifted);
            default:             term_next = VW'(prod);
        endcase
    end

    assign acc_next = s2_reg.first_k ? term_reg : acc_reg + term_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
            result.valid <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg     <= cmd.rd;
            s2_v_reg     <= s1_v_reg;
            result.valid <= s2_v_reg && s2_reg.last_k;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg   <= cmd;
            s2_reg   <= s1_reg;
            term_reg <= term_next;
            if (s2_v_reg)
            begin
                acc_reg <= acc_next;
            end
            if (s2_v_reg && s2_reg.last_k)
            begin
                result.value   <= acc_next;
                result.out_row <= s2_reg.row;
                result.out_col <= s2_reg.col;
                result.last    <= s2_reg.last_el;
            end
        end
    end

    assign stat.mode    = mode_reg;
    assign stat.rows    = clamp_dim(a_rows_reg);
    assign stat.cols    = clamp_dim(a_cols_reg);
    assign stat.bcols   = clamp_dim(b_cols_reg);
    assign stat.adv     = adv;
    assign stat.cfg_hit = cfg_hit;
    assign stat.done    = result.valid && result.ready && result.last;
endmodule

// ===== rtl/matrix_arithmetic_unit_core.sv =====
// channel   dir  payload                           transfer when
// load      in   element                           load.valid && load.ready
// result    out  value, out_row, out_col, last     result.valid && result.ready
// cfg       in   cfg_index, cfg_data               cfg_we (no handshake)
//
// each loaded element is written into its store; the element that completes
// the load starts the result walk, during which load.ready is low
// add, subtract and scale give one result a cycle, multiply one product a cycle,
// through the shared multiplier and the single read port of each store, while
// the result side accepts; multiply forms a_rows * b_cols * a_cols products in all
// result stalls freeze the whole read/multiply/accumulate pipeline in place
// reset clears control and restores the register defaults; stores need no clearing
module matrix_arithmetic_unit_core #(
    parameter int MAX_DIM       = 8,
    parameter int ELEMENT_WIDTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration writes
    input  logic                               cfg_we,
    input  logic [mau_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mau_pkg::CFG_DATA_W-1:0]     cfg_data,
    // element stream, A row-major then, except in scale mode, B row-major
    mau_load_if.sink                           load,
    // result stream, row-major
    mau_result_if.source                       result
);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // command and status between the sequencer and the datapath
    mau_pkg::cmd_t    cmd;
    mau_pkg::status_t stat;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr_a;
    logic [AW-1:0]    rd_addr_b;

    // sequencer: load count, result walk and dot product index
    mau_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (load.valid),
        .in_ready  (load.ready),
        .stat      (stat),
        .cmd       (cmd),
        .wr_addr   (wr_addr),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b)
    );

    // datapath: registers, stores, term stage, accumulator, output register
    mau_dp #(.MAX_DIM(MAX_DIM), .ELEMENT_WIDTH(ELEMENT_WIDTH)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .element   (load.element),
        .cmd       (cmd),
        .wr_addr   (wr_addr),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .stat      (stat),
        .result    (result)
    );
endmodule

// ===== rtl/mau_chk.sv =====
module mau_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          load_valid,
    input logic                          load_ready,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic                          res_last,
    input logic [mau_pkg::VALUE_W-1:0]   res_value
);
    // no loading while a result is still on offer
    a_no_load_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        load_ready |-> !res_valid)
        else $error("load open while result pending");

    // the final result ends the burst
    a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready && res_last) |=> !res_valid)
        else $error("result after last");

    // stalled result stays offered
    a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> res_valid)
        else $error("result withdrawn");

    // stalled value holds
    a_value_held: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> $stable(res_value))
        else $error("result value changed under stall");

    // a load transfer never coincides with a result transfer
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (load_valid && load_ready) |-> !(res_valid && res_ready))
        else $error("load and result transfer together");
endmodule

bind matrix_arithmetic_unit_core mau_chk u_mau_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (load.valid),
    .load_ready (load.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_last   (result.last),
    .res_value  (result.value)
);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int MAX_DIM       = 8;
    localparam int ELEM_W        = 16;
    localparam int STORE_DEPTH   = MAX_DIM * MAX_DIM;
    localparam int Q_FRAC        = 8;      // fraction bits of the q8.8 scale factor
    localparam int REG_COUNT     = 5;      // indexes at and above this hit no register
    localparam int STALL_LIMIT   = 4000;   // cycles without any transfer before giving up
    localparam int SETTLE_CYCLES = 8;      // covers the multiply tail after the last result
    localparam int DRAIN_CYCLES  = 20;
    localparam int LONG_HOLD     = 300;
    localparam int RANDOM_ITEMS  = 60;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [mau_pkg::VALUE_W-1:0] value;
        logic [mau_pkg::IDX_W-1:0]   row;
        logic [mau_pkg::IDX_W-1:0]   col;
        logic                        last;
    } result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                           cfg_we    = 1'b0;
    logic [mau_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [mau_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    mau_load_if #(.ELEMENT_WIDTH(ELEM_W)) load_ch ();
    mau_result_if                         res_ch ();

    matrix_arithmetic_unit_core #(
        .MAX_DIM       (MAX_DIM),
        .ELEMENT_WIDTH (ELEM_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .load      (load_ch),
        .result    (res_ch)
    );

    // 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // model of the unit: register copies, both stores, load position
    // ------------------------------------------------------------------
    mau_pkg::mode_t                       cfg_mode;
    logic [mau_pkg::DIM_W-1:0]            cfg_rows;
    logic [mau_pkg::DIM_W-1:0]            cfg_cols;
    logic [mau_pkg::DIM_W-1:0]            cfg_bcols;
    logic signed [mau_pkg::SCALAR_W-1:0]  cfg_scalar;
    logic signed [ELEM_W-1:0]             mat_a [STORE_DEPTH];
    logic signed [ELEM_W-1:0]             mat_b [STORE_DEPTH];
    int                                   elems_loaded;

    result_t pending_results[$];   // results still owed by the unit

    int  items_sent  = 0;
    int  mismatches  = 0;
    bit  idle_on     = 1'b1;       // random gaps on both channels when set
    int  sink_hold   = 0;          // long hold-off request for the result side
    int  quiet_cycles = 0;

    // dimension 0 counts as 1, anything past MAX_DIM as MAX_DIM
    function automatic int clamp_dim(input logic [mau_pkg::DIM_W-1:0] d);
        if (d == 0)
            return 1;
        if (d > MAX_DIM)
            return MAX_DIM;
        return int'(d);
    endfunction

    // elements in one full load under the current settings
    function automatic int job_length();
        int na;
        na = clamp_dim(cfg_rows) * clamp_dim(cfg_cols);
        case (cfg_mode)
            mau_pkg::MODE_SCALE: return na;
            mau_pkg::MODE_MUL:   return na + clamp_dim(cfg_cols) * clamp_dim(cfg_bcols);
            default:             return 2 * na;
        endcase
    endfunction

    // store one accepted element; on the closing element queue the result matrix
    task automatic absorb_element(input logic signed [ELEM_W-1:0] e);
        int                                 rows;
        int                                 cols;
        int                                 bc;
        int                                 na;
        int                                 ocols;
        int                                 idx;
        logic signed [mau_pkg::VALUE_W-1:0] v;
        logic signed [31:0]                 prod;
        result_t                            item;
        rows = clamp_dim(cfg_rows);
        cols = clamp_dim(cfg_cols);
        bc   = clamp_dim(cfg_bcols);
        na   = rows * cols;
        if (elems_loaded < na)
            mat_a[elems_loaded] = e;
        else
            mat_b[elems_loaded - na] = e;
        elems_loaded++;
        if (elems_loaded == job_length())
        begin
            elems_loaded = 0;
            ocols = (cfg_mode == mau_pkg::MODE_MUL) ? bc : cols;
            for (int r = 0; r < rows; r++)
            begin
                for (int c = 0; c < ocols; c++)
                begin
                    idx = r * cols + c;
                    case (cfg_mode)
                        mau_pkg::MODE_ADD: v = mat_a[idx] + mat_b[idx];
                        mau_pkg::MODE_SUB: v = mat_a[idx] - mat_b[idx];
                        mau_pkg::MODE_SCALE:
                        begin
                            // floor division by 256 through the arithmetic shift
                            prod = mat_a[idx] * cfg_scalar;
                            v = prod >>> Q_FRAC;
                        end
                        default:
                        begin
                            v = '0;
                            for (int k = 0; k < cols; k++)
                                v = v + mat_a[r * cols + k] * mat_b[k * bc + c];
                        end
                    endcase
                    item.value = v;
                    item.row   = mau_pkg::IDX_W'(r);
                    item.col   = mau_pkg::IDX_W'(c);
                    item.last  = (r == rows - 1) && (c == ocols - 1);
                    pending_results.push_back(item);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // random bits above the register width, the model masks them off
    function automatic logic [mau_pkg::CFG_DATA_W-1:0] with_noise(
        input logic [mau_pkg::CFG_DATA_W-1:0] v,
        input int w);
        logic [mau_pkg::CFG_DATA_W-1:0] keep;
        keep = ~({mau_pkg::CFG_DATA_W{1'b1}} << w);
        return (mau_pkg::CFG_DATA_W'($urandom) & ~keep) | (v & keep);
    endfunction

    function automatic logic signed [ELEM_W-1:0] rand_element();
        case ($urandom_range(0, 15))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return '0;
            3:       return '1;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    // mostly small sizes, some large, a few out of range
    function automatic logic [mau_pkg::DIM_W-1:0] rand_dim();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 13)
            return mau_pkg::DIM_W'($urandom_range(1, 3));
        if (pick < 18)
            return mau_pkg::DIM_W'($urandom_range(4, MAX_DIM));
        if (pick == 18)
            return '0;
        return mau_pkg::DIM_W'($urandom_range(MAX_DIM + 1, (1 << mau_pkg::DIM_W) - 1));
    endfunction

    // register write at a falling edge, taken at the next rising edge
    task automatic write_reg(input logic [mau_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mau_pkg::CFG_DATA_W-1:0] data);
        bit hit;
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
        hit = 1'b1;
        case (idx)
            mau_pkg::REG_OP_MODE:
                cfg_mode = mau_pkg::mode_t'(data[$bits(mau_pkg::mode_t)-1:0]);
            mau_pkg::REG_A_ROWS:  cfg_rows   = data[mau_pkg::DIM_W-1:0];
            mau_pkg::REG_A_COLS:  cfg_cols   = data[mau_pkg::DIM_W-1:0];
            mau_pkg::REG_B_COLS:  cfg_bcols  = data[mau_pkg::DIM_W-1:0];
            mau_pkg::REG_SCALAR:  cfg_scalar = data[mau_pkg::SCALAR_W-1:0];
            default:              hit = 1'b0;
        endcase
        // any real register write throws away a partial load
        if (hit)
            elems_loaded = 0;
    endtask

    task automatic set_config(input mau_pkg::mode_t mode, input int rows, input int cols,
                              input int bcols);
        write_reg(mau_pkg::REG_OP_MODE,
                  with_noise(mau_pkg::CFG_DATA_W'(mode), $bits(mau_pkg::mode_t)));
        write_reg(mau_pkg::REG_A_ROWS,
                  with_noise(mau_pkg::CFG_DATA_W'(rows), mau_pkg::DIM_W));
        write_reg(mau_pkg::REG_A_COLS,
                  with_noise(mau_pkg::CFG_DATA_W'(cols), mau_pkg::DIM_W));
        write_reg(mau_pkg::REG_B_COLS,
                  with_noise(mau_pkg::CFG_DATA_W'(bcols), mau_pkg::DIM_W));
    endtask

    // one element transfer; entered and left at a falling edge with valid high
    task automatic send_element(input logic signed [ELEM_W-1:0] e);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            load_ch.valid = 1'b0;
            repeat (pick_gap()) @(negedge clk);
        end
        load_ch.valid   = 1'b1;
        load_ch.element = e;
        do
            @(posedge clk);
        while (!load_ch.ready);
        absorb_element(e);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic release_load();
        load_ch.valid = 1'b0;
    endtask

    task automatic send_job();
        int n;
        n = job_length();
        repeat (n) send_element(rand_element());
    endtask

    // sender stops until every owed result has come, then the unit settles
    task automatic wait_drained();
        release_load();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset settings: 8x8 times 8x8 multiply, then scale with the unit factor
    task automatic test_reset_defaults();
        send_job();
        wait_drained();
        write_reg(mau_pkg::REG_OP_MODE,
                  with_noise(mau_pkg::CFG_DATA_W'(mau_pkg::MODE_SCALE),
                             $bits(mau_pkg::mode_t)));
        write_reg(mau_pkg::REG_A_ROWS,
                  with_noise(mau_pkg::CFG_DATA_W'(1), mau_pkg::DIM_W));
        write_reg(mau_pkg::REG_A_COLS,
                  with_noise(mau_pkg::CFG_DATA_W'(2), mau_pkg::DIM_W));
        send_element(16'sh7fff);
        send_element(16'sh8000);
        wait_drained();
    endtask

    task automatic test_add_sub_extremes();
        set_config(mau_pkg::MODE_ADD, 1, 2, 1);
        send_element(16'sh7fff);
        send_element(16'sh8000);
        send_element(16'sh7fff);
        send_element(16'sh8000);
        wait_drained();
        set_config(mau_pkg::MODE_SUB, 1, 2, 1);
        send_element(16'sh7fff);
        send_element(16'sh8000);
        send_element(16'sh8000);
        send_element(16'sh7fff);
        wait_drained();
    endtask

    // most negative and most positive factors, including floor of negatives
    task automatic test_scale_extremes();
        set_config(mau_pkg::MODE_SCALE, 1, 3, 1);
        write_reg(mau_pkg::REG_SCALAR, 16'h8000);
        send_element(16'sh7fff);
        send_element(16'sh8000);
        send_element(16'shffff);
        wait_drained();
        write_reg(mau_pkg::REG_SCALAR, 16'h7fff);
        write_reg(mau_pkg::REG_A_COLS,
                  with_noise(mau_pkg::CFG_DATA_W'(1), mau_pkg::DIM_W));
        send_element(16'shffff);
        wait_drained();
    endtask

    task automatic test_multiply_extremes();
        set_config(mau_pkg::MODE_MUL, 1, 2, 1);
        repeat (4) send_element(16'sh8000);
        wait_drained();
    endtask

    // zero dimensions act as one, oversized ones as MAX_DIM
    task automatic test_dimension_clamp();
        set_config(mau_pkg::MODE_MUL, 0, 0, (1 << mau_pkg::DIM_W) - 1);
        send_job();
        wait_drained();
    endtask

    // a register write mid-load restarts it; a write past the list does not
    task automatic test_partial_load();
        int n;
        repeat (3)
        begin
            set_config(mau_pkg::mode_t'(2'($urandom_range(0, 3))), $urandom_range(1, 3),
                       $urandom_range(2, 3), $urandom_range(1, 3));
            n = job_length();
            repeat ($urandom_range(1, n - 1)) send_element(rand_element());
            release_load();
            repeat (SETTLE_CYCLES) @(negedge clk);
            write_reg(mau_pkg::REG_OP_MODE,
                      with_noise(mau_pkg::CFG_DATA_W'(cfg_mode), $bits(mau_pkg::mode_t)));
            repeat ($urandom_range(1, n - 1)) send_element(rand_element());
            release_load();
            repeat (SETTLE_CYCLES) @(negedge clk);
            write_reg(mau_pkg::CFG_IDX_W'($urandom_range(REG_COUNT,
                                                         (1 << mau_pkg::CFG_IDX_W) - 1)),
                      mau_pkg::CFG_DATA_W'($urandom));
            do
                send_element(rand_element());
            while (elems_loaded != 0);
            wait_drained();
        end
    endtask

    // result side holds off while loads keep coming, so the unit backs up
    task automatic test_backpressure();
        idle_on = 1'b0;
        set_config(mau_pkg::MODE_ADD, 4, 4, 1);
        sink_hold = LONG_HOLD;
        repeat (3) send_job();
        wait_drained();
        set_config(mau_pkg::MODE_MUL, 3, 3, 3);
        sink_hold = LONG_HOLD;
        repeat (2) send_job();
        wait_drained();
        idle_on = 1'b1;
    endtask

    // random settings, a few back-to-back loads per setting
    task automatic test_random_jobs();
        int start;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1))
                write_reg(mau_pkg::REG_OP_MODE,
                          with_noise(mau_pkg::CFG_DATA_W'($urandom_range(0, 3)),
                                     $bits(mau_pkg::mode_t)));
            if ($urandom_range(0, 1))
                write_reg(mau_pkg::REG_A_ROWS,
                          with_noise(mau_pkg::CFG_DATA_W'(rand_dim()), mau_pkg::DIM_W));
            if ($urandom_range(0, 1))
                write_reg(mau_pkg::REG_A_COLS,
                          with_noise(mau_pkg::CFG_DATA_W'(rand_dim()), mau_pkg::DIM_W));
            if ($urandom_range(0, 1))
                write_reg(mau_pkg::REG_B_COLS,
                          with_noise(mau_pkg::CFG_DATA_W'(rand_dim()), mau_pkg::DIM_W));
            if ($urandom_range(0, 1))
                write_reg(mau_pkg::REG_SCALAR,
                          ($urandom_range(0, 3) == 0) ? 16'h8000
                                                      : mau_pkg::CFG_DATA_W'($urandom));
            repeat ($urandom_range(1, 3)) send_job();
            wait_drained();
        end
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // result side: random stalls plus long hold-offs on request
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int span;
        res_ch.ready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (sink_hold > 0)
            begin
                span = sink_hold;
                sink_hold = 0;
                res_ch.ready = 1'b0;
                repeat (span) @(negedge clk);
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                res_ch.ready = 1'b0;
                repeat (pick_gap()) @(negedge clk);
            end
            else
            begin
                res_ch.ready = 1'b1;
                @(negedge clk);
            end
        end
    end

    // every result transfer against the oldest owed result
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: value %0d row %0d col %0d last %0b",
                             $signed(res_ch.value), res_ch.out_row, res_ch.out_col,
                             res_ch.last);
            end
            else
            begin
                want = pending_results.pop_front();
                if (res_ch.value !== want.value || res_ch.out_row !== want.row ||
                    res_ch.out_col !== want.col || res_ch.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display(
                            "mismatch: expected %0d r%0d c%0d last %0b got %0d r%0d c%0d last %0b",
                            $signed(want.value), want.row, want.col, want.last,
                            $signed(res_ch.value), res_ch.out_row, res_ch.out_col,
                            res_ch.last);
                end
            end
        end
    end

    // no transfer on either channel for too long means the unit hung
    always @(posedge clk)
    begin
        if (!rst_n || (load_ch.valid && load_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL matrix_arithmetic_unit_core");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin : run
        load_ch.valid   = 1'b0;
        load_ch.element = '0;
        // register values after reset
        cfg_mode     = mau_pkg::MODE_RST;
        cfg_rows     = mau_pkg::DIM_RST;
        cfg_cols     = mau_pkg::DIM_RST;
        cfg_bcols    = mau_pkg::DIM_RST;
        cfg_scalar   = mau_pkg::SCALAR_RST;
        elems_loaded = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_add_sub_extremes();
        test_scale_extremes();
        test_multiply_extremes();
        test_dimension_clamp();
        test_partial_load();
        test_backpressure();
        test_random_jobs();

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS matrix_arithmetic_unit_core");
        else
            $display("FAIL matrix_arithmetic_unit_core");
        $finish;
    end

endmodule
